FILE: rtl/amp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package amp_pkg;

	// Fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int POS_W    = 12;
	localparam int IN_DIM_W = 7;
	localparam int OUT_DIM_W = 4;
	localparam int CFG_W    = 7;
	localparam int REG_IDX_W = 3;
	// Bound dividend: (out bins) * (in dim) + out bins - 1
	localparam int NUM_W    = IN_DIM_W + OUT_DIM_W;

	// Register indices
	localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REPORT_POS = 3'd4;

	// Register reset values
	localparam logic [IN_DIM_W-1:0]  IN_HEIGHT_RST  = 7'd64;
	localparam logic [IN_DIM_W-1:0]  IN_WIDTH_RST   = 7'd64;
	localparam logic [OUT_DIM_W-1:0] OUT_HEIGHT_RST = 4'd1;
	localparam logic [OUT_DIM_W-1:0] OUT_WIDTH_RST  = 4'd1;

	// Effective plane and bin geometry, already clamped
	typedef struct packed {
		logic [IN_DIM_W-1:0]  h;
		logic [IN_DIM_W-1:0]  w;
		logic [OUT_DIM_W-1:0] oh;
		logic [OUT_DIM_W-1:0] ow;
		logic                 report;
	} dims_t;

	// One pooled result word
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] max_value;
		logic [POS_W-1:0]           max_position;
		logic                       last_of_plane;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

`default_nettype wire

FILE: rtl/adaptive_max_pool_2d_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Throughput: samples are taken one a cycle while a plane loads; at the plane end the loader
// stalls while the pool engine finds the bounds and scans each bin, one store read a cycle,
// and while it waits to emit into a full result queue.
// Order: each bin result follows the previous one after four 11-bit serial divisions for the
// bin bounds, then the scan; the first follows the last sample.
// Reset: asynchronous, active low; registers return to 64x64 in, 1x1 out, no position.
module adaptive_max_pool_2d_core #(
	parameter int MAX_IN_DIM  = 64,
	parameter int MAX_OUT_DIM = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// sample words in
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic signed [amp_pkg::SAMPLE_W-1:0] sample,
	// result words out
	output logic                                     empty,
	input  wire logic                                pop,
	output logic signed [amp_pkg::SAMPLE_W-1:0]      max_value,
	output logic [amp_pkg::POS_W-1:0]                max_position,
	output logic                                     last_of_plane,
	// register writes
	input  wire logic                                cfg_write,
	input  wire logic [amp_pkg::REG_IDX_W-1:0]       cfg_index,
	input  wire logic [amp_pkg::CFG_W-1:0]           cfg_data
);

	localparam int DEPTH  = MAX_IN_DIM * MAX_IN_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMD_W  = 1 + ADDR_W + amp_pkg::SAMPLE_W;
	localparam logic [8:0] MAX_IN = 9'(MAX_IN_DIM);
	localparam logic [amp_pkg::OUT_DIM_W-1:0] MAX_OUT = amp_pkg::OUT_DIM_W'(MAX_OUT_DIM);

	logic [amp_pkg::IN_DIM_W-1:0]  in_height_q;
	logic [amp_pkg::IN_DIM_W-1:0]  in_width_q;
	logic [amp_pkg::OUT_DIM_W-1:0] out_height_q;
	logic [amp_pkg::OUT_DIM_W-1:0] out_width_q;
	logic                          report_q;
	logic                          cfg_known;
	amp_pkg::dims_t                dims;

	logic                          f_cmd_push;
	logic [amp_pkg::SAMPLE_W-1:0]  f_cmd_sample;
	logic [ADDR_W-1:0]             f_cmd_addr;
	logic                          f_cmd_last;
	logic [CMD_W-1:0]              cmd_in;
	logic [CMD_W-1:0]              cmd_out;
	logic                          cmd_full;
	logic                          cmd_empty;
	logic                          cmd_pop;
	logic                          res_full;
	logic                          res_push;
	amp_pkg::res_t                 res_in;
	logic [amp_pkg::RES_W-1:0]     res_out;
	amp_pkg::res_t                 res_word;

	// Any known register write restarts the plane; unknown indices are dropped.
	always_comb begin
		unique case (cfg_index)
			amp_pkg::REG_IN_HEIGHT,
			amp_pkg::REG_IN_WIDTH,
			amp_pkg::REG_OUT_HEIGHT,
			amp_pkg::REG_OUT_WIDTH,
			amp_pkg::REG_REPORT_POS: cfg_known = 1'b1;
			default:                 cfg_known = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q  <= amp_pkg::IN_HEIGHT_RST;
			in_width_q   <= amp_pkg::IN_WIDTH_RST;
			out_height_q <= amp_pkg::OUT_HEIGHT_RST;
			out_width_q  <= amp_pkg::OUT_WIDTH_RST;
			report_q     <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				amp_pkg::REG_IN_HEIGHT:  in_height_q  <= cfg_data;
				amp_pkg::REG_IN_WIDTH:   in_width_q   <= cfg_data;
				amp_pkg::REG_OUT_HEIGHT: out_height_q <= cfg_data[amp_pkg::OUT_DIM_W-1:0];
				amp_pkg::REG_OUT_WIDTH:  out_width_q  <= cfg_data[amp_pkg::OUT_DIM_W-1:0];
				amp_pkg::REG_REPORT_POS: report_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp geometry: zero acts as one, oversize acts as the maximum.
	always_comb begin
		if (in_height_q == '0) begin
			dims.h = amp_pkg::IN_DIM_W'(1);
		end else if ({2'b00, in_height_q} > MAX_IN) begin
			dims.h = MAX_IN[amp_pkg::IN_DIM_W-1:0];
		end else begin
			dims.h = in_height_q;
		end
		if (in_width_q == '0) begin
			dims.w = amp_pkg::IN_DIM_W'(1);
		end else if ({2'b00, in_width_q} > MAX_IN) begin
			dims.w = MAX_IN[amp_pkg::IN_DIM_W-1:0];
		end else begin
			dims.w = in_width_q;
		end
		if (out_height_q == '0) begin
			dims.oh = amp_pkg::OUT_DIM_W'(1);
		end else if (out_height_q > MAX_OUT) begin
			dims.oh = MAX_OUT;
		end else begin
			dims.oh = out_height_q;
		end
		if (out_width_q == '0) begin
			dims.ow = amp_pkg::OUT_DIM_W'(1);
		end else if (out_width_q > MAX_OUT) begin
			dims.ow = MAX_OUT;
		end else begin
			dims.ow = out_width_q;
		end
		dims.report = report_q;
	end

	// Front: take sample words, address them and flag the plane end.
	amp_front #(
		.MAX_IN_DIM (MAX_IN_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample     (sample),
		.restart    (cfg_write && cfg_known),
		.dims       (dims),
		.cmd_full   (cmd_full),
		.cmd_push   (f_cmd_push),
		.cmd_sample (f_cmd_sample),
		.cmd_addr   (f_cmd_addr),
		.cmd_last   (f_cmd_last)
	);

	assign cmd_in = {f_cmd_last, f_cmd_addr, f_cmd_sample};

	// Short queue: hold loads while the engine scans a finished plane.
	amp_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_cmd_push),
		.din    (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.empty  (cmd_empty)
	);

	// Back: store the plane, then pool it bin by bin.
	amp_back #(
		.MAX_IN_DIM (MAX_IN_DIM)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.dims       (dims),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.cmd_sample (cmd_out[amp_pkg::SAMPLE_W-1:0]),
		.cmd_addr   (cmd_out[amp_pkg::SAMPLE_W +: ADDR_W]),
		.cmd_last   (cmd_out[CMD_W-1]),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_data   (res_in)
	);

	// Result queue: hold finished words until the consumer pops them.
	amp_fifo #(
		.WIDTH (amp_pkg::RES_W),
		.DEPTH (4)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_in),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_out),
		.empty  (empty)
	);

	assign res_word      = amp_pkg::res_t'(res_out);
	assign max_value     = res_word.max_value;
	assign max_position  = res_word.max_position;
	assign last_of_plane = res_word.last_of_plane;

endmodule

`default_nettype wire

FILE: rtl/amp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module amp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      dout,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/amp_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module amp_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [amp_pkg::NUM_W-1:0]     num,
	input  wire logic [amp_pkg::OUT_DIM_W-1:0] den,
	output logic                               done,
	output logic [amp_pkg::NUM_W-1:0]          quo
);

	localparam int NW    = amp_pkg::NUM_W;
	localparam int DW    = amp_pkg::OUT_DIM_W;
	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DW:0]      shifted;
	logic [DW:0]      diff;
	logic             fits;

	assign shifted = {rem_q, quo_q[NW-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = !diff[DW];
	assign done    = done_q;
	assign quo     = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/amp_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Loader: count samples, give each its store address, mark the plane end
module amp_front #(
	parameter int MAX_IN_DIM = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [amp_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                         restart,
	input  wire amp_pkg::dims_t               dims,
	input  wire logic                         cmd_full,
	output logic                              cmd_push,
	output logic [amp_pkg::SAMPLE_W-1:0]      cmd_sample,
	output logic [((MAX_IN_DIM*MAX_IN_DIM > 1) ? $clog2(MAX_IN_DIM*MAX_IN_DIM) : 1)-1:0] cmd_addr,
	output logic                              cmd_last
);

	localparam int DEPTH  = MAX_IN_DIM * MAX_IN_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PROD_W = 2 * amp_pkg::IN_DIM_W;
	localparam int CMP_W  = (ADDR_W + 1 > PROD_W) ? ADDR_W + 1 : PROD_W;

	logic [ADDR_W-1:0] count_q;
	logic [PROD_W-1:0] size;
	logic              accept;
	logic              last;

	assign size     = PROD_W'(dims.h) * PROD_W'(dims.w);
	assign last     = (CMP_W'(count_q) + CMP_W'(1)) == CMP_W'(size);
	assign accept   = push && !cmd_full;
	assign full     = cmd_full;
	assign cmd_push = accept;
	assign cmd_sample = sample;
	assign cmd_addr = count_q;
	assign cmd_last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (restart) begin
			// drop any part-loaded plane
			count_q <= '0;
		end else if (accept) begin
			count_q <= last ? '0 : count_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/amp_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Pool engine: write loaded words to the store, then scan each bin for its maximum
module amp_back #(
	parameter int MAX_IN_DIM = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire amp_pkg::dims_t               dims,
	input  wire logic                         cmd_empty,
	output logic                              cmd_pop,
	input  wire logic [amp_pkg::SAMPLE_W-1:0] cmd_sample,
	input  wire logic [((MAX_IN_DIM*MAX_IN_DIM > 1) ? $clog2(MAX_IN_DIM*MAX_IN_DIM) : 1)-1:0] cmd_addr,
	input  wire logic                         cmd_last,
	input  wire logic                         res_full,
	output logic                              res_push,
	output amp_pkg::res_t                     res_data
);

	localparam int DEPTH  = MAX_IN_DIM * MAX_IN_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DIM_W  = amp_pkg::IN_DIM_W;
	localparam int OD_W   = amp_pkg::OUT_DIM_W;
	localparam int NW     = amp_pkg::NUM_W;
	localparam int PROD_W = 2 * DIM_W;
	localparam int PW     = (ADDR_W > amp_pkg::POS_W) ? ADDR_W : amp_pkg::POS_W;

	localparam logic [2:0] S_LOAD      = 3'd0;
	localparam logic [2:0] S_DIV_GO    = 3'd1;
	localparam logic [2:0] S_DIV_WAIT  = 3'd2;
	localparam logic [2:0] S_SCAN_INIT = 3'd3;
	localparam logic [2:0] S_SCAN      = 3'd4;
	localparam logic [2:0] S_DRAIN     = 3'd5;
	localparam logic [2:0] S_EMIT      = 3'd6;

	localparam logic [1:0] B_RB = 2'd0;
	localparam logic [1:0] B_RE = 2'd1;
	localparam logic [1:0] B_CB = 2'd2;
	localparam logic [1:0] B_CE = 2'd3;

	logic [2:0]        state_q;
	logic [1:0]        sel_q;
	logic [OD_W-1:0]   r_q;
	logic [OD_W-1:0]   c_q;
	logic [DIM_W-1:0]  rb_q;
	logic [DIM_W-1:0]  re_q;
	logic [DIM_W-1:0]  cb_q;
	logic [DIM_W-1:0]  ce_q;
	logic [DIM_W-1:0]  y_q;
	logic [DIM_W-1:0]  x_q;
	logic [ADDR_W-1:0] row_base_q;
	logic              first_q;

	logic                          rd_s1;
	logic                          first_s1;
	logic [ADDR_W-1:0]             pos_s1;
	logic signed [amp_pkg::SAMPLE_W-1:0] rd_data_s1;
	logic signed [amp_pkg::SAMPLE_W-1:0] best_q;
	logic [ADDR_W-1:0]             best_pos_q;

	logic [amp_pkg::SAMPLE_W-1:0] store_q [DEPTH];

	logic              div_start;
	logic [NW-1:0]     div_num;
	logic [OD_W-1:0]   div_den;
	logic              div_done;
	logic [NW-1:0]     div_quo;
	logic [DIM_W-1:0]  quo_dim;
	logic              mem_we;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic              last_x;
	logic              last_y;
	logic              last_c;
	logic              last_r;
	logic [PW-1:0]     pos_wide;

	amp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign quo_dim = div_quo[DIM_W-1:0];
	assign rd_addr = row_base_q + ADDR_W'(x_q);
	assign last_x  = (x_q + 1'b1) == ce_q;
	assign last_y  = (y_q + 1'b1) == re_q;
	assign last_c  = (c_q + 1'b1) == dims.ow;
	assign last_r  = (r_q + 1'b1) == dims.oh;

	// Bounds: begin = floor(k*n/bins), end = ceil((k+1)*n/bins)
	always_comb begin
		unique case (sel_q)
			B_RB: div_num = NW'(r_q) * NW'(dims.h);
			B_RE: div_num = NW'(r_q + 1'b1) * NW'(dims.h) + NW'(dims.oh) - NW'(1);
			B_CB: div_num = NW'(c_q) * NW'(dims.w);
			B_CE: div_num = NW'(c_q + 1'b1) * NW'(dims.w) + NW'(dims.ow) - NW'(1);
			default: div_num = '0;
		endcase
		div_den = (sel_q == B_RB || sel_q == B_RE) ? dims.oh : dims.ow;
	end

	always_comb begin
		cmd_pop   = 1'b0;
		mem_we    = 1'b0;
		div_start = 1'b0;
		rd_en     = 1'b0;
		res_push  = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				cmd_pop = !cmd_empty;
				mem_we  = !cmd_empty;
			end
			S_DIV_GO: div_start = 1'b1;
			S_SCAN:   rd_en = 1'b1;
			S_EMIT:   res_push = !res_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			sel_q      <= B_RB;
			r_q        <= '0;
			c_q        <= '0;
			first_q    <= 1'b0;
			rd_s1      <= 1'b0;
			first_s1   <= 1'b0;
		end else begin
			rd_s1    <= rd_en;
			first_s1 <= rd_en && first_q;
			unique case (state_q)
				S_LOAD: begin
					if (!cmd_empty && cmd_last) begin
						r_q     <= '0;
						c_q     <= '0;
						sel_q   <= B_RB;
						state_q <= S_DIV_GO;
					end
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (div_done) begin
						sel_q   <= sel_q + 1'b1;
						state_q <= (sel_q == B_CE) ? S_SCAN_INIT : S_DIV_GO;
					end
				end
				S_SCAN_INIT: begin
					first_q <= 1'b1;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					first_q <= 1'b0;
					if (last_x && last_y) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_EMIT;
				S_EMIT: begin
					if (!res_full) begin
						sel_q <= B_RB;
						if (last_c && last_r) begin
							state_q <= S_LOAD;
						end else if (last_c) begin
							c_q     <= '0;
							r_q     <= r_q + 1'b1;
							state_q <= S_DIV_GO;
						end else begin
							c_q     <= c_q + 1'b1;
							state_q <= S_DIV_GO;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Bounds, scan counters and running maximum
	always_ff @(posedge clk) begin
		if (state_q == S_DIV_WAIT && div_done) begin
			unique case (sel_q)
				B_RB: rb_q <= quo_dim;
				B_RE: re_q <= quo_dim;
				B_CB: cb_q <= quo_dim;
				B_CE: ce_q <= quo_dim;
				default: ;
			endcase
		end
		if (state_q == S_SCAN_INIT) begin
			row_base_q <= ADDR_W'(PROD_W'(rb_q) * PROD_W'(dims.w));
			y_q        <= rb_q;
			x_q        <= cb_q;
		end else if (state_q == S_SCAN) begin
			if (last_x) begin
				x_q        <= cb_q;
				y_q        <= y_q + 1'b1;
				row_base_q <= row_base_q + ADDR_W'(dims.w);
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
		pos_s1 <= rd_addr;
		// strict compare keeps the earliest maximum
		if (rd_s1 && (first_s1 || rd_data_s1 > best_q)) begin
			best_q     <= rd_data_s1;
			best_pos_q <= pos_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[cmd_addr] <= cmd_sample;
		end
		if (rd_en) begin
			rd_data_s1 <= store_q[rd_addr];
		end
	end

	assign pos_wide = PW'(best_pos_q);

	always_comb begin
		res_data.max_value     = best_q;
		res_data.max_position  = dims.report ? pos_wide[amp_pkg::POS_W-1:0] : '0;
		res_data.last_of_plane = last_c && last_r;
	end

endmodule

`default_nettype wire

FILE: tb/sv/adaptive_max_pool_2d_checker.sv
`timescale 1ns / 1ps

module adaptive_max_pool_2d_checker #(
	parameter int MAX_IN_DIM  = 64,
	parameter int MAX_OUT_DIM = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	input  wire logic                                full,
	input  wire logic signed [amp_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                empty,
	input  wire logic                                pop,
	input  wire logic signed [amp_pkg::SAMPLE_W-1:0] max_value,
	input  wire logic [amp_pkg::POS_W-1:0]           max_position,
	input  wire logic                                last_of_plane,
	input  wire logic                                cfg_write,
	input  wire logic [amp_pkg::REG_IDX_W-1:0]       cfg_index,
	input  wire logic [amp_pkg::CFG_W-1:0]           cfg_data,
	output int                                       mismatches,
	output int                                       pooled_words,
	output int                                       planes_done,
	output int                                       words_due
);

	localparam int STORE_DEPTH  = MAX_IN_DIM * MAX_IN_DIM;
	localparam int REPORT_LIMIT = 10;

	// Shadow of the register file
	logic [amp_pkg::IN_DIM_W-1:0]  rows_reg;
	logic [amp_pkg::IN_DIM_W-1:0]  cols_reg;
	logic [amp_pkg::OUT_DIM_W-1:0] bin_rows_reg;
	logic [amp_pkg::OUT_DIM_W-1:0] bin_cols_reg;
	logic                          report_reg;

	logic signed [amp_pkg::SAMPLE_W-1:0] plane_mem [0:STORE_DEPTH-1];
	int                                  fill;
	amp_pkg::res_t                       pooled_q[$];
	amp_pkg::res_t                       want;
	amp_pkg::res_t                       got;
	int                                  bad_count;
	int                                  word_count;
	int                                  plane_count;
	int                                  plane_size;

	function automatic int clamp_dim(input int v, input int hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Queue one max word per bin of the plane just completed, bins in raster order
	function automatic void pool_plane();
		int h, w, oh, ow;
		int rb, re, cb, ce;
		int pos, best_pos;
		logic signed [amp_pkg::SAMPLE_W-1:0] best;
		amp_pkg::res_t word;
		h  = clamp_dim(rows_reg, MAX_IN_DIM);
		w  = clamp_dim(cols_reg, MAX_IN_DIM);
		oh = clamp_dim(bin_rows_reg, MAX_OUT_DIM);
		ow = clamp_dim(bin_cols_reg, MAX_OUT_DIM);
		for (int r = 0; r < oh; r++) begin
			rb = (r * h) / oh;
			re = ((r + 1) * h + oh - 1) / oh;
			for (int c = 0; c < ow; c++) begin
				cb = (c * w) / ow;
				ce = ((c + 1) * w + ow - 1) / ow;
				best_pos = rb * w + cb;
				best = plane_mem[best_pos];
				for (int y = rb; y < re; y++) begin
					for (int x = cb; x < ce; x++) begin
						pos = y * w + x;
						// strict compare: the earliest of equal maxima stays
						if (plane_mem[pos] > best) begin
							best = plane_mem[pos];
							best_pos = pos;
						end
					end
				end
				word.max_value = best;
				word.max_position = report_reg ? amp_pkg::POS_W'(best_pos) : '0;
				word.last_of_plane = (r == oh - 1) && (c == ow - 1);
				pooled_q = {pooled_q, word};
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg = amp_pkg::IN_HEIGHT_RST;
			cols_reg = amp_pkg::IN_WIDTH_RST;
			bin_rows_reg = amp_pkg::OUT_HEIGHT_RST;
			bin_cols_reg = amp_pkg::OUT_WIDTH_RST;
			report_reg = 1'b0;
			fill = 0;
			pooled_q.delete();
			bad_count = 0;
			word_count = 0;
			plane_count = 0;
		end else begin
			if (pop && !empty) begin
				got.max_value = max_value;
				got.max_position = max_position;
				got.last_of_plane = last_of_plane;
				if (pooled_q.size() == 0) begin
					if (bad_count < REPORT_LIMIT)
						$display("%0t: word with nothing due: value %0d position %0d last %0b",
							$realtime, got.max_value, got.max_position, got.last_of_plane);
					bad_count++;
				end else begin
					want = pooled_q.pop_front();
					if (got !== want) begin
						if (bad_count < REPORT_LIMIT) begin
							$display("%0t: word %0d: expected value %0d position %0d last %0b",
								$realtime, word_count, want.max_value, want.max_position,
								want.last_of_plane);
							$display("%0t: word %0d: got value %0d position %0d last %0b",
								$realtime, word_count, got.max_value, got.max_position,
								got.last_of_plane);
						end
						bad_count++;
					end
				end
				word_count++;
			end

			if (cfg_write) begin
				// any known register restarts the plane; spare indexes do nothing
				case (cfg_index)
					amp_pkg::REG_IN_HEIGHT: begin
						rows_reg = cfg_data[amp_pkg::IN_DIM_W-1:0];
						fill = 0;
					end
					amp_pkg::REG_IN_WIDTH: begin
						cols_reg = cfg_data[amp_pkg::IN_DIM_W-1:0];
						fill = 0;
					end
					amp_pkg::REG_OUT_HEIGHT: begin
						bin_rows_reg = cfg_data[amp_pkg::OUT_DIM_W-1:0];
						fill = 0;
					end
					amp_pkg::REG_OUT_WIDTH: begin
						bin_cols_reg = cfg_data[amp_pkg::OUT_DIM_W-1:0];
						fill = 0;
					end
					amp_pkg::REG_REPORT_POS: begin
						report_reg = cfg_data[0];
						fill = 0;
					end
					default: ;
				endcase
			end

			if (push && !full) begin
				plane_size = clamp_dim(rows_reg, MAX_IN_DIM) * clamp_dim(cols_reg, MAX_IN_DIM);
				plane_mem[fill] = sample;
				fill++;
				if (fill >= plane_size) begin
					fill = 0;
					pool_plane();
					plane_count++;
				end
			end
		end
		mismatches <= bad_count;
		pooled_words <= word_count;
		planes_done <= plane_count;
		words_due <= pooled_q.size();
	end

endmodule

FILE: tb/sv/adaptive_max_pool_2d_core_test.sv
`timescale 1ns / 1ps

module adaptive_max_pool_2d_core_test;

	localparam int MAX_IN_DIM  = 64;
	localparam int MAX_OUT_DIM = 8;

	// Idle wait after the last due word; it covers any work still in flight once nothing is due.
	localparam int SETTLE_CYCLES = 128;
	// Longest honest quiet stretch is a settle wait or one 64-sample bin scan of a
	// 64x1 plane; allow many times that.
	localparam int WATCHDOG_LIMIT = 20000;
	// Rough size of the random part; only decides when stimulus stops
	localparam int RANDOM_SAMPLES = 120;
	localparam int RANDOM_WORDS   = 60;

	// Spare register indexes, which the block must ignore
	localparam logic [amp_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [amp_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum int {
		FILL_ANY,   // full 16-bit random
		FILL_TIES,  // -1, 0, +1 only, so ties are common
		FILL_RAILS  // the two extremes, -32768 and +32767, plus -1 and 0
	} fill_e;

	logic                                clk;
	logic                                arst_n;
	logic                                push;
	logic                                full;
	logic signed [amp_pkg::SAMPLE_W-1:0] sample;
	logic                                empty;
	logic                                pop;
	logic signed [amp_pkg::SAMPLE_W-1:0] max_value;
	logic [amp_pkg::POS_W-1:0]           max_position;
	logic                                last_of_plane;
	logic                                cfg_write;
	logic [amp_pkg::REG_IDX_W-1:0]       cfg_index;
	logic [amp_pkg::CFG_W-1:0]           cfg_data;

	int mismatches;
	int pooled_words;
	int planes_done;
	int words_due;

	// Idle pattern selectors: when set the side never waits between words
	bit tx_steady;
	bit rx_steady;

	int                           samples_sent;
	int                           random_sent;
	int                           reg_writes;
	logic [amp_pkg::IN_DIM_W-1:0] rows_now;
	logic [amp_pkg::IN_DIM_W-1:0] cols_now;

	wire moved = (push && !full) || (pop && !empty);

	adaptive_max_pool_2d_core #(
		.MAX_IN_DIM (MAX_IN_DIM),
		.MAX_OUT_DIM(MAX_OUT_DIM)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample       (sample),
		.empty        (empty),
		.pop          (pop),
		.max_value    (max_value),
		.max_position (max_position),
		.last_of_plane(last_of_plane),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	adaptive_max_pool_2d_checker #(
		.MAX_IN_DIM (MAX_IN_DIM),
		.MAX_OUT_DIM(MAX_OUT_DIM)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample       (sample),
		.empty        (empty),
		.pop          (pop),
		.max_value    (max_value),
		.max_position (max_position),
		.last_of_plane(last_of_plane),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pooled_words (pooled_words),
		.planes_done  (planes_done),
		.words_due    (words_due)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Effective input dimension: zero acts as one, oversize clamps to the store edge
	function automatic int eff_in_dim(input logic [amp_pkg::IN_DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_IN_DIM)
			return MAX_IN_DIM;
		return v;
	endfunction

	function automatic int plane_len();
		return eff_in_dim(rows_now) * eff_in_dim(cols_now);
	endfunction

	function automatic logic signed [amp_pkg::SAMPLE_W-1:0] draw_sample(input fill_e mode);
		case (mode)
			FILL_TIES:
				return amp_pkg::SAMPLE_W'($urandom_range(0, 2) - 1);
			FILL_RAILS:
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					2: return -16'sd1;
					default: return '0;
				endcase
			default:
				return amp_pkg::SAMPLE_W'($urandom());
		endcase
	endfunction

	// Mostly small plane sides, now and then zero or an oversize value
	function automatic logic [amp_pkg::IN_DIM_W-1:0] draw_dim(input bit allow_big);
		case ($urandom_range(0, 11))
			0: return '0;
			1: return allow_big
				? amp_pkg::IN_DIM_W'($urandom_range(MAX_IN_DIM + 1,
					(1 << amp_pkg::IN_DIM_W) - 1))
				: amp_pkg::IN_DIM_W'(1);
			default: return amp_pkg::IN_DIM_W'($urandom_range(1, 6));
		endcase
	endfunction

	// Bin count in the low nibble; junk in the upper data bits must not matter
	function automatic logic [amp_pkg::CFG_W-1:0] draw_bins();
		logic [amp_pkg::OUT_DIM_W-1:0] nibble;
		case ($urandom_range(0, 7))
			0: nibble = '0;
			1: nibble = amp_pkg::OUT_DIM_W'($urandom_range(MAX_OUT_DIM + 1,
				(1 << amp_pkg::OUT_DIM_W) - 1));
			default: nibble = amp_pkg::OUT_DIM_W'($urandom_range(1, 4));
		endcase
		return {(amp_pkg::CFG_W - amp_pkg::OUT_DIM_W)'($urandom()), nibble};
	endfunction

	// Offer one sample word after a random gap, or none when tx_steady, and hold it until taken.
	// Push stays high on return so back-to-back words follow without a gap.
	task automatic send_sample(input logic signed [amp_pkg::SAMPLE_W-1:0] value);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		sample <= value;
		@(posedge clk);
		while (full)
			@(posedge clk);
		samples_sent++;
	endtask

	task automatic send_plane(input fill_e mode, input int count);
		for (int i = 0; i < count; i++)
			send_sample(draw_sample(mode));
	endtask

	// Drop push, wait for every due word, then let the engine go quiet
	task automatic settle();
		push <= 1'b0;
		do
			@(posedge clk);
		while (words_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the idle cycle after it keeps writes from sharing an edge
	task automatic write_reg(input logic [amp_pkg::REG_IDX_W-1:0] idx,
		input logic [amp_pkg::CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		reg_writes++;
		if (idx == amp_pkg::REG_IN_HEIGHT)
			rows_now = data[amp_pkg::IN_DIM_W-1:0];
		else if (idx == amp_pkg::REG_IN_WIDTH)
			cols_now = data[amp_pkg::IN_DIM_W-1:0];
	endtask

	task automatic randomise_geometry();
		logic [amp_pkg::IN_DIM_W-1:0] rows;
		logic [amp_pkg::IN_DIM_W-1:0] cols;
		rows = draw_dim(1'b1);
		// keep the plane small: an oversize side pairs with a side of at most one
		if (rows > MAX_IN_DIM)
			cols = amp_pkg::IN_DIM_W'($urandom_range(0, 1));
		else
			cols = draw_dim(rows <= 1);
		write_reg(amp_pkg::REG_IN_HEIGHT, rows);
		write_reg(amp_pkg::REG_IN_WIDTH, cols);
		write_reg(amp_pkg::REG_OUT_HEIGHT, draw_bins());
		write_reg(amp_pkg::REG_OUT_WIDTH, draw_bins());
		write_reg(amp_pkg::REG_REPORT_POS, amp_pkg::CFG_W'($urandom()));
		if ($urandom_range(0, 3) == 0)
			write_reg(amp_pkg::REG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
				amp_pkg::CFG_W'($urandom()));
	endtask

	// Result side: random pop gaps, pop held high across words when the gap is zero
	initial begin : drain
		int gap;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = rx_steady ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
		end
	end

	// Give up when no word moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (moved)
				quiet = 0;
			else
				quiet++;
		end
		$display("no progress for %0d cycles, %0d words still due", WATCHDOG_LIMIT, words_due);
		$display("adaptive_max_pool_2d_core regression: fail");
		$finish;
	end

	initial begin : stimulus
		int    planes;
		bit    paused;
		fill_e mode;

		push <= 1'b0;
		sample <= '0;
		cfg_write <= 1'b0;
		cfg_index <= amp_pkg::REG_IN_HEIGHT;
		cfg_data <= '0;
		arst_n <= 1'b0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		samples_sent = 0;
		random_sent = 0;
		reg_writes = 0;
		paused = 1'b0;
		rows_now = amp_pkg::IN_HEIGHT_RST;
		cols_now = amp_pkg::IN_WIDTH_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2x3 plane under the reset bins: one 1x1 bin, positions off.
		// Both rails and alternating bit patterns, max tied at two places.
		write_reg(amp_pkg::REG_IN_HEIGHT, 7'd2);
		write_reg(amp_pkg::REG_IN_WIDTH, 7'd3);
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		send_sample(16'sh5555);
		send_sample(16'sh7FFF);
		send_sample(16'sh0000);
		send_sample(16'shAAAA);
		settle();

		// One bin per sample with positions on; a spare-index write in mid plane
		// must neither restart the plane nor change anything.
		write_reg(amp_pkg::REG_REPORT_POS, 7'd1);
		write_reg(amp_pkg::REG_OUT_HEIGHT, 7'd2);
		write_reg(amp_pkg::REG_OUT_WIDTH, 7'd3);
		send_sample(-16'sd5);
		send_sample(16'sd300);
		send_sample(16'sh8000);
		send_sample(16'sd1);
		settle();
		write_reg(REG_SPARE_HI, 7'h7F);
		send_sample(16'sh7FFF);
		send_sample(-16'sd1);
		settle();

		// Drop a partial plane by a register write, then zero height and more
		// bins than columns: 1x4 plane in eight overlapping bins, tied maxima.
		send_sample(16'sd99);
		send_sample(16'sd98);
		settle();
		write_reg(amp_pkg::REG_IN_HEIGHT, 7'd0);
		write_reg(amp_pkg::REG_IN_WIDTH, 7'd4);
		write_reg(amp_pkg::REG_OUT_HEIGHT, 7'd0);
		write_reg(amp_pkg::REG_OUT_WIDTH, 7'd15);
		send_sample(16'sd7);
		send_sample(16'sd7);
		send_sample(-16'sd3);
		send_sample(16'sd7);
		settle();

		// Oversize height clamps to 64 rows of one column; upper data bits set on
		// the bin counts. No idling on either side for this stretch.
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		write_reg(amp_pkg::REG_IN_HEIGHT, 7'd127);
		write_reg(amp_pkg::REG_IN_WIDTH, 7'd1);
		write_reg(amp_pkg::REG_OUT_HEIGHT, 7'h7F);
		write_reg(amp_pkg::REG_OUT_WIDTH, 7'h10);
		send_plane(FILL_ANY, plane_len());
		random_sent += plane_len();

		// Random geometry and content, one to three planes per setting
		while (random_sent < RANDOM_SAMPLES || pooled_words < RANDOM_WORDS) begin
			settle();
			randomise_geometry();
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			// first pass runs two planes so the hold-off below happens at least once
			planes = paused ? $urandom_range(1, 3) : 2;
			for (int p = 0; p < planes; p++) begin
				if (p > 0 && (!paused || $urandom_range(0, 3) == 0)) begin
					// hold the next plane until every word of the last has drained
					push <= 1'b0;
					do
						@(posedge clk);
					while (words_due != 0);
					paused = 1'b1;
				end
				mode = fill_e'($urandom_range(0, 2));
				send_plane(mode, plane_len());
				random_sent += plane_len();
			end
			// sometimes leave a partial plane for the next register write to drop
			if (plane_len() > 1 && $urandom_range(0, 4) == 0) begin
				planes = $urandom_range(1, plane_len() - 1);
				send_plane(FILL_ANY, planes);
				random_sent += planes;
			end
		end

		settle();
		$display("covered %0d sample words over %0d completed planes with %0d register writes",
			samples_sent, planes_done, reg_writes);
		$display("checked %0d pooled words, %0d in error", pooled_words, mismatches);
		if (mismatches == 0 && words_due == 0)
			$display("adaptive_max_pool_2d_core regression: pass");
		else
			$display("adaptive_max_pool_2d_core regression: fail");
		$finish;
	end

endmodule
